// File: rtl/core/tfdh_pkg.sv
// Types and constants shared by the tank fill / drain / heat controller.
// No dependencies.
`default_nettype none

package tfdh_pkg;

    // Command bytes
    localparam logic [7:0] CMD_START = 8'h31;
    localparam logic [7:0] CMD_DRAIN = 8'h32;
    localparam logic [7:0] CMD_FILL  = 8'h33;
    localparam logic [7:0] CMD_STOP  = 8'h34;

    // Mode codes as reported on the result
    localparam logic [1:0] MODE_CODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_CODE_RECIRC = 2'd1;
    localparam logic [1:0] MODE_CODE_DRAIN  = 2'd2;
    localparam logic [1:0] MODE_CODE_FILL   = 2'd3;

    // Configuration register indexes
    localparam int          CFG_IDX_W        = 2;
    localparam int          CFG_DATA_W       = 16;
    localparam logic [1:0]  CFG_IDX_TARGET   = 2'd0;
    localparam logic [1:0]  CFG_IDX_MARGIN   = 2'd1;
    localparam logic [1:0]  CFG_IDX_HOLD_LIM = 2'd2;

    // Reset values of the configuration registers
    localparam logic [11:0] TARGET_RST   = 12'd400;
    localparam logic [7:0]  MARGIN_RST   = 8'd32;
    localparam logic [15:0] HOLD_LIM_RST = 16'd300;

    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_RECIRC = 4'b0010,
        MODE_DRAIN  = 4'b0100,
        MODE_FILL   = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [7:0]  command;
        logic        level_low_ok;
        logic        level_high;
        logic [11:0] temperature;
        logic        timer_tick;
    } t_in;

    typedef struct packed {
        logic [1:0] mode;
        logic       recirc_valve;
        logic       drain_valve;
        logic       supply_valve;
        logic       pump_on;
        logic       heater_on;
        logic       persist_request;
    } t_out;

    typedef struct packed {
        logic [11:0] target_temperature;
        logic [7:0]  heat_margin;
        logic [15:0] fill_hold_limit;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic        heater;
        logic        timer_running;
        logic [15:0] tick_count;
    } t_state;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        case (m)
            MODE_RECIRC: c = MODE_CODE_RECIRC;
            MODE_DRAIN:  c = MODE_CODE_DRAIN;
            MODE_FILL:   c = MODE_CODE_FILL;
            default:     c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tfdh_step.sv
// One control pass: next mode, heater and fill timer state, and the drives.
// Depends on tfdh_pkg.
`default_nettype none

module tfdh_step (
    input  var tfdh_pkg::t_state i_state,
    input  var tfdh_pkg::t_in    i_in,
    input  var tfdh_pkg::t_cfg   i_cfg,
    output tfdh_pkg::t_state     o_state,
    output tfdh_pkg::t_out       o_out
);

    logic signed [13:0] temp_s;
    logic signed [13:0] target_s;
    logic signed [13:0] on_thresh;
    logic               heat_on_cond;
    logic               heat_off_cond;

    assign temp_s        = {{2{i_in.temperature[11]}}, i_in.temperature};
    assign target_s      = {{2{i_cfg.target_temperature[11]}}, i_cfg.target_temperature};
    assign on_thresh     = target_s - $signed({6'd0, i_cfg.heat_margin});
    assign heat_on_cond  = (temp_s <= on_thresh) && i_in.level_high;
    assign heat_off_cond = (temp_s >= target_s);

    always_comb begin
        tfdh_pkg::t_mode next;
        logic            heater;
        logic            running;
        logic [15:0]     count;
        logic            rv;
        logic            dv;
        logic            sv;
        logic            pump;

        next    = i_state.mode;
        heater  = i_state.heater;
        running = i_state.timer_running;
        count   = i_state.tick_count;
        rv      = 1'b0;
        dv      = 1'b0;
        sv      = 1'b0;
        pump    = 1'b0;

        case (i_state.mode)
            tfdh_pkg::MODE_IDLE: begin
                heater = 1'b0;
                if (i_in.command == tfdh_pkg::CMD_START) begin
                    next = tfdh_pkg::MODE_RECIRC;
                end else if (i_in.command == tfdh_pkg::CMD_DRAIN) begin
                    next = tfdh_pkg::MODE_DRAIN;
                end else if (i_in.command == tfdh_pkg::CMD_FILL && !i_in.level_high) begin
                    next = tfdh_pkg::MODE_FILL;
                end
            end
            tfdh_pkg::MODE_RECIRC: begin
                rv   = 1'b1;
                pump = 1'b1;
                if (heat_on_cond) begin
                    heater = 1'b1;
                end else if (heat_off_cond) begin
                    heater = 1'b0;
                end
                if (i_in.command == tfdh_pkg::CMD_STOP || !i_in.level_low_ok) begin
                    next = tfdh_pkg::MODE_IDLE;
                end else if (i_in.command == tfdh_pkg::CMD_FILL && !i_in.level_high) begin
                    next = tfdh_pkg::MODE_FILL;
                end else if (i_in.command == tfdh_pkg::CMD_DRAIN) begin
                    next = tfdh_pkg::MODE_DRAIN;
                end
            end
            tfdh_pkg::MODE_DRAIN: begin
                heater = 1'b0;
                dv     = 1'b1;
                pump   = 1'b1;
                if (i_in.command == tfdh_pkg::CMD_STOP || !i_in.level_low_ok) begin
                    next = tfdh_pkg::MODE_IDLE;
                end else if (i_in.command == tfdh_pkg::CMD_FILL && !i_in.level_high) begin
                    next = tfdh_pkg::MODE_FILL;
                end else if (i_in.command == tfdh_pkg::CMD_START) begin
                    next = tfdh_pkg::MODE_RECIRC;
                end
            end
            default: begin
                heater = 1'b0;
                sv     = 1'b1;
                // full level arms the timer in the same pass
                if (i_in.level_high) begin
                    running = 1'b1;
                end
                if (i_in.timer_tick && running) begin
                    if (count > i_cfg.fill_hold_limit) begin
                        next = tfdh_pkg::MODE_IDLE;
                    end else if (count != tfdh_pkg::TICK_MAX) begin
                        count = count + 16'd1;
                    end
                end
                // command still wins over the timeout
                if (i_in.command == tfdh_pkg::CMD_STOP) begin
                    next = tfdh_pkg::MODE_IDLE;
                end else if (i_in.command == tfdh_pkg::CMD_DRAIN && i_in.level_low_ok) begin
                    next = tfdh_pkg::MODE_DRAIN;
                end else if (i_in.command == tfdh_pkg::CMD_START && i_in.level_low_ok) begin
                    next = tfdh_pkg::MODE_RECIRC;
                end
            end
        endcase

        if (next != tfdh_pkg::MODE_FILL) begin
            running = 1'b0;
            count   = 16'd0;
        end

        o_state.mode          = next;
        o_state.heater        = heater;
        o_state.timer_running = running;
        o_state.tick_count    = count;

        o_out.mode            = tfdh_pkg::mode_code(next);
        o_out.recirc_valve    = rv;
        o_out.drain_valve     = dv;
        o_out.supply_valve    = sv;
        o_out.pump_on         = pump;
        o_out.heater_on       = (i_state.mode == tfdh_pkg::MODE_RECIRC) ? heater : 1'b0;
        o_out.persist_request = (next != i_state.mode);
    end

endmodule

`default_nettype wire

// File: rtl/core/tank_fill_drain_heat_controller.sv
// Top level of the tank fill / drain / heat controller: input register,
// control pass, result register, configuration registers. Depends on tfdh_pkg, tfdh_step.
//
//  channel  direction  handshake                      payload
//  in       sink       i_in_valid / o_in_stall        i_in_data  (t_in)
//  out      source     o_out_valid / i_out_stall      o_out_data (t_out)
//  cfg      sink       i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One transaction per clock while the result is not stalled; the input register, then the
// pass into the result register, lie between input and result.
// Reset is synchronous on i_rst_n; mode idle, heater off, timer cleared, config to defaults.
// A stalled result holds the input register; the input stalls only when both are full.
// Configuration is always ready; writes to an index past the list are dropped.
`default_nettype none

module tank_fill_drain_heat_controller (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  var tfdh_pkg::t_in                    i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output tfdh_pkg::t_out                       o_out_data,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [tfdh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [tfdh_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    tfdh_pkg::t_in    r_in;
    logic             r_in_valid;
    tfdh_pkg::t_out   r_out;
    logic             r_out_valid;
    tfdh_pkg::t_state r_state;
    tfdh_pkg::t_cfg   r_cfg;

    tfdh_pkg::t_state n_state;
    tfdh_pkg::t_out   n_out;

    logic out_blocked;
    logic advance;
    logic in_take;
    logic cfg_take;

    assign out_blocked = r_out_valid && i_out_stall;
    assign advance     = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_take    = i_cfg_valid && o_cfg_ready;

    tfdh_step u_step (
        .i_state (r_state),
        .i_in    (r_in),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_out   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{mode: tfdh_pkg::MODE_IDLE, heater: 1'b0,
                             timer_running: 1'b0, tick_count: 16'd0};
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{target_temperature: tfdh_pkg::TARGET_RST,
                       heat_margin:        tfdh_pkg::MARGIN_RST,
                       fill_hold_limit:    tfdh_pkg::HOLD_LIM_RST};
        end else if (cfg_take) begin
            case (i_cfg_index)
                tfdh_pkg::CFG_IDX_TARGET:   r_cfg.target_temperature <= i_cfg_data[11:0];
                tfdh_pkg::CFG_IDX_MARGIN:   r_cfg.heat_margin        <= i_cfg_data[7:0];
                tfdh_pkg::CFG_IDX_HOLD_LIM: r_cfg.fill_hold_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // fill timer state only lives in fill mode
    a_timer_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.timer_running || r_state.tick_count != 16'd0)
            |-> r_state.mode == tfdh_pkg::MODE_FILL)
        else $error("fill timer active outside fill mode");

    // heater is only driven together with recirculation
    a_heater_recirc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.heater_on) |-> o_out_data.recirc_valve)
        else $error("heater on without recirculation");

    // the reported mode tracks the stored mode once a pass lands
    a_mode_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_data.mode == tfdh_pkg::mode_code(r_state.mode))
        else $error("result mode differs from stored mode");

    // a mode change is reported exactly when the stored mode moved
    a_persist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_data.persist_request == (r_state.mode != $past(r_state.mode)))
        else $error("persist flag does not match mode change");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the tank fill / drain / heat controller: directed passes, then
// random control passes over several register settings, each result checked against a predictor or a typed want.
// Depends on tfdh_pkg and tank_fill_drain_heat_controller.
`timescale 1ns / 100ps

module tb_top;

    localparam int         CLK_HALF       = 5;
    localparam int         RESET_CYCLES   = 6;
    localparam int         N_STEER        = 25;
    localparam int         HOLD_CYCLES    = 80;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam logic [1:0] CFG_IDX_SPARE  = 2'd3;

    typedef struct packed {
        logic           typed;
        tfdh_pkg::t_out want;
    } t_pass_note;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    tfdh_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_stall;
    tfdh_pkg::t_out o_out_data;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [1:0]     i_cfg_index;
    logic [15:0]    i_cfg_data;

    tank_fill_drain_heat_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor copy of the registers and the control state
    logic signed [11:0] set_target   = tfdh_pkg::TARGET_RST;
    logic [7:0]         set_margin   = tfdh_pkg::MARGIN_RST;
    logic [15:0]        set_hold_lim = tfdh_pkg::HOLD_LIM_RST;
    logic [1:0]         pass_mode    = tfdh_pkg::MODE_CODE_IDLE;
    logic               heat_latch   = 1'b0;
    logic               fill_armed   = 1'b0;
    logic [15:0]        fill_ticks   = 16'd0;

    tfdh_pkg::t_out result_q[$];
    t_pass_note     note_q[$];
    int             mismatch_count = 0;
    int             quiet_cycles   = 0;
    int             tx_idle_pct    = 0;
    int             rx_idle_pct    = 0;
    logic           hold_req       = 1'b0;

    tfdh_pkg::t_in  stim_tab[N_STEER];
    tfdh_pkg::t_out want_tab[N_STEER];
    logic           typed_tab[N_STEER];

    always #CLK_HALF i_clk = ~i_clk;

    // One control pass: drives from the mode held at the start, then the mode change
    function automatic tfdh_pkg::t_out tank_pass(input tfdh_pkg::t_in x);
        tfdh_pkg::t_out r;
        logic [1:0]     was;
        logic [1:0]     nxt;
        int             temp_v;
        int             tgt_v;
        int             on_at;
        r      = '0;
        was    = pass_mode;
        nxt    = was;
        temp_v = int'($signed(x.temperature));
        tgt_v  = int'(set_target);
        on_at  = tgt_v - int'(set_margin);
        case (was)
            tfdh_pkg::MODE_CODE_IDLE: begin
                heat_latch = 1'b0;
                if (x.command == tfdh_pkg::CMD_START)
                    nxt = tfdh_pkg::MODE_CODE_RECIRC;
                else if (x.command == tfdh_pkg::CMD_DRAIN)
                    nxt = tfdh_pkg::MODE_CODE_DRAIN;
                else if (x.command == tfdh_pkg::CMD_FILL && !x.level_high)
                    nxt = tfdh_pkg::MODE_CODE_FILL;
            end
            tfdh_pkg::MODE_CODE_RECIRC: begin
                r.recirc_valve = 1'b1;
                r.pump_on      = 1'b1;
                // hysteresis: on only when full and at or below the lower edge
                if (temp_v <= on_at && x.level_high)
                    heat_latch = 1'b1;
                else if (temp_v >= tgt_v)
                    heat_latch = 1'b0;
                if (x.command == tfdh_pkg::CMD_STOP || !x.level_low_ok)
                    nxt = tfdh_pkg::MODE_CODE_IDLE;
                else if (x.command == tfdh_pkg::CMD_FILL && !x.level_high)
                    nxt = tfdh_pkg::MODE_CODE_FILL;
                else if (x.command == tfdh_pkg::CMD_DRAIN)
                    nxt = tfdh_pkg::MODE_CODE_DRAIN;
            end
            tfdh_pkg::MODE_CODE_DRAIN: begin
                heat_latch    = 1'b0;
                r.drain_valve = 1'b1;
                r.pump_on     = 1'b1;
                if (x.command == tfdh_pkg::CMD_STOP || !x.level_low_ok)
                    nxt = tfdh_pkg::MODE_CODE_IDLE;
                else if (x.command == tfdh_pkg::CMD_FILL && !x.level_high)
                    nxt = tfdh_pkg::MODE_CODE_FILL;
                else if (x.command == tfdh_pkg::CMD_START)
                    nxt = tfdh_pkg::MODE_CODE_RECIRC;
            end
            default: begin
                heat_latch     = 1'b0;
                r.supply_valve = 1'b1;
                if (x.level_high)
                    fill_armed = 1'b1;
                if (x.timer_tick && fill_armed) begin
                    if (fill_ticks > set_hold_lim)
                        nxt = tfdh_pkg::MODE_CODE_IDLE;
                    else if (fill_ticks != tfdh_pkg::TICK_MAX)
                        fill_ticks = fill_ticks + 16'd1;
                end
                // command still applies after the timer
                if (x.command == tfdh_pkg::CMD_STOP)
                    nxt = tfdh_pkg::MODE_CODE_IDLE;
                else if (x.command == tfdh_pkg::CMD_DRAIN && x.level_low_ok)
                    nxt = tfdh_pkg::MODE_CODE_DRAIN;
                else if (x.command == tfdh_pkg::CMD_START && x.level_low_ok)
                    nxt = tfdh_pkg::MODE_CODE_RECIRC;
            end
        endcase
        if (nxt != tfdh_pkg::MODE_CODE_FILL) begin
            fill_armed = 1'b0;
            fill_ticks = 16'd0;
        end
        pass_mode         = nxt;
        r.mode            = nxt;
        r.heater_on       = (was == tfdh_pkg::MODE_CODE_RECIRC) ? heat_latch : 1'b0;
        r.persist_request = (nxt != was);
        return r;
    endfunction

    function automatic tfdh_pkg::t_in pass_in(input logic [7:0] cmd, input int lo,
                                              input int hi, input int temp, input int tk);
        tfdh_pkg::t_in x;
        x.command      = cmd;
        x.level_low_ok = 1'(lo);
        x.level_high   = 1'(hi);
        x.temperature  = temp[11:0];
        x.timer_tick   = 1'(tk);
        return x;
    endfunction

    // Mostly quiet passes with the odd command; temperatures cluster round the heater band
    function automatic tfdh_pkg::t_in random_pass();
        tfdh_pkg::t_in x;
        int            pick;
        int            span;
        int            t;
        int            tgt_v;
        tgt_v = int'(set_target);
        span  = int'(set_margin) + 8;
        pick  = $urandom_range(99);
        if (pick < 82)
            x.command = 8'h00;
        else if (pick < 97) begin
            case ($urandom_range(3))
                0:       x.command = tfdh_pkg::CMD_START;
                1:       x.command = tfdh_pkg::CMD_DRAIN;
                2:       x.command = tfdh_pkg::CMD_FILL;
                default: x.command = tfdh_pkg::CMD_STOP;
            endcase
        end else
            x.command = 8'($urandom_range(255));
        case ($urandom_range(7))
            0:       t = tgt_v - int'(set_margin) + int'($urandom_range(2)) - 1;
            1:       t = tgt_v + int'($urandom_range(2)) - 1;
            2, 3:    t = int'($urandom_range(3071)) - 1024;
            default: t = tgt_v - span + int'($urandom_range(2 * span));
        endcase
        if (t < -1024)
            t = -1024;
        else if (t > 2047)
            t = 2047;
        x.temperature  = t[11:0];
        x.level_low_ok = ($urandom_range(99) < 92);
        x.level_high   = 1'($urandom_range(1));
        x.timer_tick   = 1'($urandom_range(1));
        return x;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        mismatch_count++;
        $display("%0t: mismatch on %s, got %0h, want %0h", $realtime, what, got, want);
    endtask

    task automatic offer_pass(input tfdh_pkg::t_in x, input logic typed,
                              input tfdh_pkg::t_out want);
        t_pass_note n;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        n.typed = typed;
        n.want  = want;
        note_q.push_back(n);
        i_in_valid <= 1'b1;
        i_in_data  <= x;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        repeat (n)
            offer_pass(random_pass(), 1'b0, '0);
    endtask

    // Drop valid and let every pending result come back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Unused upper data bits carry junk; the registers keep only their own width
    task automatic program_regs(input int tgt, input int margin, input int lim);
        logic [31:0] tv;
        logic [31:0] mv;
        logic [31:0] lv;
        logic [15:0] junk;
        tv   = tgt;
        mv   = margin;
        lv   = lim;
        junk = 16'($urandom);
        write_reg(tfdh_pkg::CFG_IDX_TARGET, {junk[15:12], tv[11:0]});
        write_reg(tfdh_pkg::CFG_IDX_MARGIN, {junk[7:0], mv[7:0]});
        write_reg(tfdh_pkg::CFG_IDX_HOLD_LIM, lv[15:0]);
    endtask

    always @(posedge i_clk) begin : in_mon
        tfdh_pkg::t_out pred;
        t_pass_note     n;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            pred = tank_pass(i_in_data);
            n    = note_q.pop_front();
            result_q.push_back(n.typed ? n.want : pred);
        end
    end

    always @(posedge i_clk) begin : out_mon
        tfdh_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_q.size() == 0)
                flag_mismatch("unexpected result", 16'(o_out_data), 16'd0);
            else begin
                want = result_q.pop_front();
                if (o_out_data.mode !== want.mode)
                    flag_mismatch("mode", 16'(o_out_data.mode), 16'(want.mode));
                if (o_out_data.recirc_valve !== want.recirc_valve)
                    flag_mismatch("recirc_valve", 16'(o_out_data.recirc_valve),
                                  16'(want.recirc_valve));
                if (o_out_data.drain_valve !== want.drain_valve)
                    flag_mismatch("drain_valve", 16'(o_out_data.drain_valve),
                                  16'(want.drain_valve));
                if (o_out_data.supply_valve !== want.supply_valve)
                    flag_mismatch("supply_valve", 16'(o_out_data.supply_valve),
                                  16'(want.supply_valve));
                if (o_out_data.pump_on !== want.pump_on)
                    flag_mismatch("pump_on", 16'(o_out_data.pump_on), 16'(want.pump_on));
                if (o_out_data.heater_on !== want.heater_on)
                    flag_mismatch("heater_on", 16'(o_out_data.heater_on),
                                  16'(want.heater_on));
                if (o_out_data.persist_request !== want.persist_request)
                    flag_mismatch("persist_request", 16'(o_out_data.persist_request),
                                  16'(want.persist_request));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tfdh_pkg::CFG_IDX_TARGET:   set_target   = i_cfg_data[11:0];
                tfdh_pkg::CFG_IDX_MARGIN:   set_margin   = i_cfg_data[7:0];
                tfdh_pkg::CFG_IDX_HOLD_LIM: set_hold_lim = i_cfg_data;
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random stall, or one long hold-off on request
    initial begin : rx_side
        logic hold_done;
        hold_done   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial begin : stimulus
        int i;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = tfdh_pkg::CFG_IDX_TARGET;
        i_cfg_data  = 16'd0;

        // Directed passes at reset settings (target 400, margin 32).
        // Typed results: {mode, recirc, drain, supply, pump, heater, persist}
        for (i = 0; i < N_STEER; i++) begin
            typed_tab[i] = 1'b0;
            want_tab[i]  = '0;
        end
        stim_tab[0]  = pass_in(8'h00,     1, 0,     0, 0);   // quiet after reset
        typed_tab[0] = 1'b1;
        want_tab[0]  = {tfdh_pkg::MODE_CODE_IDLE, 6'b000000};
        stim_tab[1]  = pass_in(tfdh_pkg::CMD_START, 1, 0,   100, 0);
        typed_tab[1] = 1'b1;
        want_tab[1]  = {tfdh_pkg::MODE_CODE_RECIRC, 6'b000001};
        stim_tab[2]  = pass_in(8'h00,     1, 1,   368, 0);   // exactly target - margin
        typed_tab[2] = 1'b1;
        want_tab[2]  = {tfdh_pkg::MODE_CODE_RECIRC, 6'b100110};
        stim_tab[3]  = pass_in(8'h00,     1, 1,   399, 0);   // holds on
        stim_tab[4]  = pass_in(8'h00,     1, 1,   400, 0);   // off at target
        stim_tab[5]  = pass_in(8'h00,     1, 1,   369, 0);   // holds off
        stim_tab[6]  = pass_in(8'h00,     1, 0, -1024, 0);   // cold but not full
        stim_tab[7]  = pass_in(8'h00,     1, 1, -1024, 0);
        stim_tab[8]  = pass_in(8'hFF,     1, 1,  2047, 1);   // unknown command
        stim_tab[9]  = pass_in(tfdh_pkg::CMD_FILL,  1, 1,     0, 0);   // fill refused when full
        stim_tab[10] = pass_in(tfdh_pkg::CMD_DRAIN, 1, 0,     0, 0);
        stim_tab[11] = pass_in(tfdh_pkg::CMD_FILL,  1, 1,     0, 0);
        stim_tab[12] = pass_in(tfdh_pkg::CMD_START, 1, 0,     0, 0);
        stim_tab[13] = pass_in(8'h00,     0, 0,     0, 0);   // low level lost
        stim_tab[14] = pass_in(tfdh_pkg::CMD_FILL,  0, 1,     0, 0);
        stim_tab[15] = pass_in(tfdh_pkg::CMD_FILL,  0, 0,     0, 1);
        stim_tab[16] = pass_in(8'h00,     0, 0,     0, 1);   // tick before armed
        stim_tab[17] = pass_in(tfdh_pkg::CMD_START, 0, 1,     0, 1);
        stim_tab[18] = pass_in(tfdh_pkg::CMD_DRAIN, 0, 1,     0, 1);
        stim_tab[19] = pass_in(8'h80,     1, 0,     0, 1);
        stim_tab[20] = pass_in(tfdh_pkg::CMD_DRAIN, 1, 0,     0, 0);
        stim_tab[21] = pass_in(tfdh_pkg::CMD_STOP,  1, 0,     0, 0);
        typed_tab[21] = 1'b1;
        want_tab[21]  = {tfdh_pkg::MODE_CODE_IDLE, 6'b010101};
        stim_tab[22] = pass_in(tfdh_pkg::CMD_FILL,  1, 0,     0, 0);
        stim_tab[23] = pass_in(tfdh_pkg::CMD_STOP,  1, 1,     0, 1);   // arm and stop together
        typed_tab[23] = 1'b1;
        want_tab[23]  = {tfdh_pkg::MODE_CODE_IDLE, 6'b001001};
        stim_tab[24] = pass_in(tfdh_pkg::CMD_STOP,  1, 0,     0, 0);   // stop while idle
        typed_tab[24] = 1'b1;
        want_tab[24]  = {tfdh_pkg::MODE_CODE_IDLE, 6'b000000};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 14;
        rx_idle_pct = 64;
        for (i = 0; i < N_STEER; i++)
            offer_pass(stim_tab[i], typed_tab[i], want_tab[i]);
        run_random(225);
        settle();

        write_reg(CFG_IDX_SPARE, 16'($urandom));
        program_regs(2047, 255, 0);
        tx_idle_pct = 64;
        rx_idle_pct = 14;
        run_random(225);
        settle();

        program_regs(-1024, 0, 65535);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(150);
        settle();

        program_regs(int'($urandom_range(3071)) - 1024, $urandom_range(255),
                     $urandom_range(1, 12));
        hold_req = 1'b1;
        run_random(300);
        settle();

        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: tank_fill_drain_heat_controller.f
rtl/core/tfdh_pkg.sv
rtl/core/tfdh_step.sv
rtl/core/tank_fill_drain_heat_controller.sv
bench/tb_top.sv
